// ===== hw/rtl/point_set_dedup_defines.svh =====
// Assertion macros shared by the point_set_dedup RTL.
`ifndef POINT_SET_DEDUP_DEFINES_SVH
`define POINT_SET_DEDUP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that a condition holds on every rising clock edge out of reset.
`define PSD_ASSERT(lbl, ck, rn, cond, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
// Check that the consequent holds whenever the antecedent holds.
`define PSD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define PSD_ASSERT(lbl, ck, rn, cond, msg)
`define PSD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/psd_pkg.sv =====
// Package for point_set_dedup: constants, payload and chain types, helpers.
`timescale 1ns / 1ps
package psd_pkg;

    localparam int CAPACITY   = 256;
    localparam int COORD_BITS = 16;
    localparam int IN_COORD_W = 16;
    localparam int POS_W      = 8;
    localparam int TOTAL_W    = 9;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic signed [IN_COORD_W-1:0] point_x;
        logic signed [IN_COORD_W-1:0] point_y;
        logic                         start_set;
    } in_t;

    typedef struct packed {
        logic               is_new;
        logic [POS_W-1:0]   unique_position;
        logic [TOTAL_W-1:0] unique_total;
        logic               overflow;
    } out_t;

    // Query travelling down the cell row.
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic                  is_new;
        logic [IDX_W-1:0]      pos;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } query_t;

    // Finished result handed from the controller to the output stage.
    typedef struct packed {
        logic done;
        out_t res;
    } report_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REPORT
    } state_t;

    // Sign-extend an input coordinate to 32 bits, keep the low COORD_BITS.
    function automatic logic [COORD_BITS-1:0] coord_fold(input logic [IN_COORD_W-1:0] c);
        logic [31:0] w;
        w = {{(32 - IN_COORD_W){c[IN_COORD_W-1]}}, c};
        return w[COORD_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/point_set_dedup.sv =====
// Top level of point_set_dedup: cell row, controller and output stage.
// Usage:
//   point channel (point_valid/point_ready/point) takes one 2-D point per
//   transaction; start_set = 1 empties the set before that point is taken.
//   result channel (result_valid/result_ready/result) returns one result per
//   point: is_new, unique_position, unique_total and overflow.
// Search: a point travels down a row of CAPACITY cells, one cell per
//   cycle; its result is built from the query leaving the last cell and
//   registered in the output stage (an overflowed point skips the row).
// Flow: one point in flight at a time; the next point can be taken the
//   cycle after the previous one leaves the row or is reported, once the
//   holding register is free.
// Reset: rst_n clears both counts and all valid flags; stored points are
//   left as they are and are only compared below the distinct count.
// Stall: a result waiting on result_ready sits in the output register while
//   the next point is searched; a second finished result parks in a one-deep
//   holding register, and point_ready drops until it drains.
`timescale 1ns / 1ps
`include "point_set_dedup_defines.svh"
module point_set_dedup import psd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic point_valid,
    output logic point_ready,
    input  in_t  point,
    output logic result_valid,
    input  logic result_ready,
    output out_t result
);

    query_t           q_chain [CAPACITY+1];
    logic [CNT_W-1:0] count;
    report_t          rpt;

    logic             out_valid_reg;
    logic             out_valid_next;
    out_t             out_reg;
    out_t             out_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    out_t             pend_reg;
    out_t             pend_next;
    logic             take;

    psd_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .pend_free   (!pend_valid_reg),
        .exit_q      (q_chain[CAPACITY]),
        .launch      (q_chain[0]),
        .count       (count),
        .rpt         (rpt)
    );

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        psd_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .idx   (IDX_W'(g)),
            .count (count),
            .q_in  (q_chain[g]),
            .q_out (q_chain[g+1])
        );
    end

    assign take = out_valid_reg && result_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (take)
        begin
            if (pend_valid_reg)
            begin
                out_next        = pend_reg;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (rpt.done)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_next       = rpt.res;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_next       = rpt.res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        pend_reg <= pend_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `PSD_ASSERT_IMP(a_pend_behind_out, clk, rst_n, pend_valid_reg, out_valid_reg,
                    "holding register ahead of output")
    `PSD_ASSERT_IMP(a_no_drop, clk, rst_n, rpt.done && pend_valid_reg, take,
                    "result arrived with both stages full")

endmodule

// ===== hw/rtl/psd_cell.sv =====
// One cell of the dedup row: holds one distinct point and passes the query on.
`timescale 1ns / 1ps
module psd_cell import psd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] idx,
    input  logic [CNT_W-1:0] count,
    input  query_t           q_in,
    output query_t           q_out
);

    logic [COORD_BITS-1:0] entry_x_reg;
    logic [COORD_BITS-1:0] entry_y_reg;
    query_t                q_reg;
    query_t                q_next;
    logic                  match;
    logic                  take;

    always_comb
    begin
        match = q_in.valid && !q_in.hit && (CNT_W'(idx) < count)
                && (entry_x_reg == q_in.x) && (entry_y_reg == q_in.y);
        // first cell past the distinct list claims a point nobody matched
        take  = q_in.valid && !q_in.hit && (CNT_W'(idx) == count);
        q_next = q_in;
        if (match)
        begin
            q_next.hit = 1'b1;
            q_next.pos = idx;
        end
        if (take)
        begin
            q_next.hit    = 1'b1;
            q_next.is_new = 1'b1;
            q_next.pos    = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_x_reg <= q_in.x;
            entry_y_reg <= q_in.y;
        end
    end

    assign q_out = q_reg;

endmodule

// ===== hw/rtl/psd_ctrl.sv =====
// Controller: set counters, query launch, overflow handling and result build.
`timescale 1ns / 1ps
`include "point_set_dedup_defines.svh"
module psd_ctrl import psd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    output logic             point_ready,
    input  in_t              point,
    input  logic             pend_free,
    input  query_t           exit_q,
    output query_t           launch,
    output logic [CNT_W-1:0] count,
    output report_t          rpt
);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] distinct_reg;
    logic [CNT_W-1:0] distinct_next;
    logic [CNT_W-1:0] appended_reg;
    logic [CNT_W-1:0] appended_next;
    query_t           launch_reg;
    query_t           launch_next;
    logic             fire;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] app_eff;
    logic             is_ovf;

    assign fire      = point_valid && point_ready;
    assign count_eff = point.start_set ? '0 : distinct_reg;
    assign app_eff   = point.start_set ? '0 : appended_reg;
    assign is_ovf    = (app_eff == CNT_W'(CAPACITY));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (fire)
                begin
                    state_next = is_ovf ? ST_REPORT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (exit_q.valid)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // counters and launch register
    always_comb
    begin
        distinct_next = distinct_reg;
        appended_next = appended_reg;
        launch_next   = '0;
        if (fire)
        begin
            distinct_next = count_eff;
            if (is_ovf)
            begin
                appended_next = app_eff;
            end
            else
            begin
                appended_next     = app_eff + CNT_W'(1);
                launch_next.valid = 1'b1;
                launch_next.x     = coord_fold(point.point_x);
                launch_next.y     = coord_fold(point.point_y);
            end
        end
        if ((state_reg == ST_SEARCH) && exit_q.valid && exit_q.is_new)
        begin
            distinct_next = distinct_reg + CNT_W'(1);
        end
    end

    // outputs
    always_comb
    begin
        point_ready = (state_reg == ST_IDLE) && pend_free;
        rpt         = '0;
        case (state_reg)
            ST_SEARCH:
            begin
                rpt.done                = exit_q.valid;
                rpt.res.is_new          = exit_q.is_new;
                rpt.res.unique_position = POS_W'(exit_q.pos);
                rpt.res.unique_total    = exit_q.is_new
                                        ? TOTAL_W'(distinct_reg + CNT_W'(1))
                                        : TOTAL_W'(distinct_reg);
            end
            ST_REPORT:
            begin
                rpt.done             = 1'b1;
                rpt.res.overflow     = 1'b1;
                rpt.res.unique_total = TOTAL_W'(distinct_reg);
            end
            default:
            begin
                rpt = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            distinct_reg <= '0;
            appended_reg <= '0;
            launch_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            distinct_reg <= distinct_next;
            appended_reg <= appended_next;
            launch_reg   <= launch_next;
        end
    end

    assign launch = launch_reg;
    assign count  = distinct_reg;

    `PSD_ASSERT(a_cnt_order, clk, rst_n, distinct_reg <= appended_reg, "distinct above appended")
    `PSD_ASSERT_IMP(a_launch_search, clk, rst_n, launch_reg.valid, state_reg == ST_SEARCH, "launch outside search")
    `PSD_ASSERT_IMP(a_exit_hit, clk, rst_n, exit_q.valid, exit_q.hit && (state_reg == ST_SEARCH), "query left row unresolved")

endmodule
